// ===== sv/segment_segment_distance_macros.svh =====
// assertion macros for the segment distance block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef SEGMENT_SEGMENT_DISTANCE_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment distance check failed");

// next-cycle implication, checked outside reset
`define SSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment distance check failed");

`endif

// ===== sv/ssd_pkg.sv =====
// shared widths, types and latency figures for the segment distance pipeline
// no dependencies; imported by every module of the block
package ssd_pkg;

  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int HALF_W     = DOT_W / 2;
  localparam int MUL_W      = 2 * HALF_W;
  localparam int WIDE_W     = 2 * MUL_W;
  localparam int PARAM_FRAC = 16;
  localparam int PARAM_W    = PARAM_FRAC + 1;
  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC;
  localparam int TNUM_W     = DOT_W + PARAM_W + 1;
  localparam int DIV_W      = WIDE_W;
  localparam int DIV_STEPS  = PARAM_FRAC;
  localparam int DIV_LAT    = DIV_STEPS + 1;
  localparam int VPROD_W    = DIFF_W + PARAM_W;
  localparam int V_W        = VPROD_W + 2;
  localparam int SQ_ROOT_W  = 29;
  localparam int SQ_W       = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W   = SQ_ROOT_W + 3;
  localparam int RAD_LSB    = 2 * PARAM_FRAC;
  localparam int DIST_W     = 25;
  localparam int DOT_LAT    = 3;
  localparam int MUL_LAT    = 2;
  localparam int LATENCY    = DOT_LAT + MUL_LAT + 1 + DIV_LAT + 2 + DIV_LAT + 3
                              + MUL_LAT + 1 + SQ_ROOT_W + 1;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d1;
    logic [2:0][DIFF_W-1:0] d2;
    logic [2:0][DIFF_W-1:0] r;
  } geom_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] e;
    logic signed [DOT_W-1:0] f;
  } dots_t;

  // travels alongside the first divider
  typedef struct packed {
    dots_t dots;
    geom_t geom;
    logic  a_zero;
    logic  e_zero;
  } side1_t;

  // travels alongside the second divider
  typedef struct packed {
    geom_t              geom;
    logic               s_div;
    logic [PARAM_W-1:0] s_fix;
    logic [PARAM_W-1:0] t_fix;
    logic               a_zero;
    logic               e_zero;
  } side2_t;

endpackage

// ===== sv/ssd_dot.sv =====
// front end: direction and offset vectors, then the five dot products
// depends on ssd_pkg; three register stages
module ssd_dot (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [2:0][ssd_pkg::COORD_W-1:0]     p1_i,
  input  logic [2:0][ssd_pkg::COORD_W-1:0]     q1_i,
  input  logic [2:0][ssd_pkg::COORD_W-1:0]     p2_i,
  input  logic [2:0][ssd_pkg::COORD_W-1:0]     q2_i,
  output logic                                 valid_o,
  output ssd_pkg::dots_t                       dots_o,
  output ssd_pkg::geom_t                       geom_o
);
  import ssd_pkg::*;

  logic [DOT_LAT-1:0] vld_q;
  geom_t geom1_d, geom1_q, geom2_q, geom3_q;
  logic signed [PROD_W-1:0] paa_q [3];
  logic signed [PROD_W-1:0] pee_q [3];
  logic signed [PROD_W-1:0] pbb_q [3];
  logic signed [PROD_W-1:0] pcc_q [3];
  logic signed [PROD_W-1:0] pff_q [3];
  dots_t dots_d, dots_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geom1_d.d1[i] = DIFF_W'($signed(q1_i[i])) - DIFF_W'($signed(p1_i[i]));
      geom1_d.d2[i] = DIFF_W'($signed(q2_i[i])) - DIFF_W'($signed(p2_i[i]));
      geom1_d.r[i]  = DIFF_W'($signed(p1_i[i])) - DIFF_W'($signed(p2_i[i]));
    end
  end

  always_comb begin
    dots_d.a = DOT_W'(paa_q[0]) + DOT_W'(paa_q[1]) + DOT_W'(paa_q[2]);
    dots_d.e = DOT_W'(pee_q[0]) + DOT_W'(pee_q[1]) + DOT_W'(pee_q[2]);
    dots_d.b = DOT_W'(pbb_q[0]) + DOT_W'(pbb_q[1]) + DOT_W'(pbb_q[2]);
    dots_d.c = DOT_W'(pcc_q[0]) + DOT_W'(pcc_q[1]) + DOT_W'(pcc_q[2]);
    dots_d.f = DOT_W'(pff_q[0]) + DOT_W'(pff_q[1]) + DOT_W'(pff_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DOT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    geom1_q <= geom1_d;
    geom2_q <= geom1_q;
    geom3_q <= geom2_q;
    for (int i = 0; i < 3; i++) begin
      paa_q[i] <= $signed(geom1_q.d1[i]) * $signed(geom1_q.d1[i]);
      pee_q[i] <= $signed(geom1_q.d2[i]) * $signed(geom1_q.d2[i]);
      pbb_q[i] <= $signed(geom1_q.d1[i]) * $signed(geom1_q.d2[i]);
      pcc_q[i] <= $signed(geom1_q.d1[i]) * $signed(geom1_q.r[i]);
      pff_q[i] <= $signed(geom1_q.d2[i]) * $signed(geom1_q.r[i]);
    end
    dots_q <= dots_d;
  end

  assign valid_o = vld_q[DOT_LAT-1];
  assign dots_o  = dots_q;
  assign geom_o  = geom3_q;

endmodule

// ===== sv/ssd_mul.sv =====
// two-stage signed multiplier built from four half-width partial products
// depends on ssd_pkg; payload only, no control state
module ssd_mul (
  input  logic                                clk_i,
  input  logic signed [ssd_pkg::MUL_W-1:0]    x_i,
  input  logic signed [ssd_pkg::MUL_W-1:0]    y_i,
  output logic signed [ssd_pkg::WIDE_W-1:0]   p_o
);
  import ssd_pkg::*;

  logic signed [HALF_W-1:0] xh, yh;
  logic signed [HALF_W:0]   xl, yl;
  logic signed [2*HALF_W-1:0] hh_q;
  logic signed [2*HALF_W:0]   hl_q, lh_q, ll_q;
  logic signed [WIDE_W-1:0]   p_q;

  assign xh = x_i[MUL_W-1:HALF_W];
  assign yh = y_i[MUL_W-1:HALF_W];
  assign xl = {1'b0, x_i[HALF_W-1:0]};
  assign yl = {1'b0, y_i[HALF_W-1:0]};

  always_ff @(posedge clk_i) begin
    hh_q <= xh * yh;
    hl_q <= xh * yl;
    lh_q <= xl * yh;
    ll_q <= xl * yl;
    p_q  <= (WIDE_W'(hh_q) <<< (2 * HALF_W))
          + ((WIDE_W'(hl_q) + WIDE_W'(lh_q)) <<< HALF_W)
          + WIDE_W'(ll_q);
  end

  assign p_o = p_q;

endmodule

// ===== sv/ssd_div.sv =====
// pipelined restoring divider giving num/den clamped to [0, 1] in Q1.16
// depends on ssd_pkg; an input stage, then one quotient bit per register stage
module ssd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [ssd_pkg::DIV_W-1:0]   num_i,
  input  logic [ssd_pkg::DIV_W-1:0]          den_i,
  output logic                               valid_o,
  output logic [ssd_pkg::PARAM_W-1:0]        quo_o
);
  import ssd_pkg::*;

  logic [DIV_STEPS:0] vld_q;
  logic [DIV_W-1:0]   rem_q  [DIV_STEPS+1];
  logic [DIV_W-1:0]   dsr_q  [DIV_STEPS+1];
  logic [PARAM_W-1:0] quo_q  [DIV_STEPS+1];
  logic               done_q [DIV_STEPS+1];
  logic               num_pos, num_ge;

  // non-positive numerator gives zero, numerator at or above den gives one
  assign num_pos = !num_i[DIV_W-1] && (num_i != '0);
  assign num_ge  = $unsigned(num_i) >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    dsr_q[0]  <= den_i;
    done_q[0] <= !num_pos || num_ge;
    quo_q[0]  <= (num_pos && num_ge) ? PARAM_ONE : '0;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DIV_W:0] rem2, diff;
    logic           ge;

    assign rem2 = {rem_q[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dsr_q[k-1]};
    assign ge   = rem2 >= {1'b0, dsr_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
      dsr_q[k]  <= dsr_q[k-1];
      done_q[k] <= done_q[k-1];
      quo_q[k]  <= done_q[k-1] ? quo_q[k-1] : {quo_q[k-1][PARAM_W-2:0], ge};
    end
  end

  assign valid_o = vld_q[DIV_STEPS];
  assign quo_o   = quo_q[DIV_STEPS];

endmodule

// ===== sv/ssd_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on ssd_pkg
module ssd_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [ssd_pkg::SQ_W-1:0]          rad_i,
  output logic                              valid_o,
  output logic [ssd_pkg::SQ_ROOT_W-1:0]     root_o
);
  import ssd_pkg::*;

  logic [SQ_ROOT_W-1:0] vld_q;
  logic [SQ_W-1:0]      rad_q  [SQ_ROOT_W];
  logic [SQ_REM_W-1:0]  rem_q  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_q [SQ_ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQ_ROOT_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_step
    logic [SQ_W-1:0]      rad_in;
    logic [SQ_REM_W-1:0]  rem_in, rem_sh, trial;
    logic [SQ_ROOT_W-1:0] root_in;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next two radicand bits, try (4 * root + 1)
    assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = SQ_REM_W'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[SQ_ROOT_W-2:0], ge};
    end
  end

  assign valid_o = vld_q[SQ_ROOT_W-1];
  assign root_o  = root_q[SQ_ROOT_W-1];

endmodule

// ===== sv/segment_segment_distance.sv =====
// throughput: one segment pair per cycle; busy_o stays low, the pipeline never stalls
// the two 17-stage dividers and the 29-stage root set most of the latency
// results cannot be held off, each is shown for one cycle under done_o
// reset: asynchronous, active low, clears all valid bits; items in flight are dropped
`include "segment_segment_distance_macros.svh"

module segment_segment_distance (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_start_x_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_start_y_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_start_z_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_end_x_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_end_y_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg1_end_z_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_start_x_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_start_y_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_start_z_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_end_x_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_end_y_i,
  input  logic signed [ssd_pkg::COORD_W-1:0]   seg2_end_z_i,
  output logic                                 done_o,
  output logic [ssd_pkg::DIST_W-1:0]           distance_o
);
  import ssd_pkg::*;

  logic  in_acc;
  logic  dot_vld;
  dots_t dots;
  geom_t geom;

  // dot product multiply stage
  logic [MUL_LAT-1:0]      m_vld_q;
  side1_t                  m_side_q [MUL_LAT];
  logic signed [WIDE_W-1:0] p_ae, p_bb, p_bf, p_ce;

  // denominator / numerator of s
  logic                     n_vld_q;
  logic signed [WIDE_W-1:0] den_q, snum_q;
  side1_t                   n_side_q;
  logic signed [DIV_W-1:0]  num1;

  // first divider
  side1_t             dv1_q [DIV_LAT];
  logic               d1_vld;
  logic [PARAM_W-1:0] d1_quo;

  // t numerator
  logic                     t_vld_q;
  logic signed [TNUM_W-1:0] tnum_d, tnum_q, tden_d, tden_q;
  logic [PARAM_W-1:0]       s0_q;
  side1_t                   t_side_q;

  // case selection ahead of the second divider
  logic                    c_vld_q;
  logic signed [DIV_W-1:0] num2_d, num2_q;
  logic [DIV_W-1:0]        den2_d, den2_q;
  side2_t                  c_side_d, c_side_q;

  // second divider
  side2_t             dv2_q [DIV_LAT];
  logic               d2_vld;
  logic [PARAM_W-1:0] d2_quo;

  // final parameters
  logic               st_vld_q;
  logic [PARAM_W-1:0] s_q, t_q;
  geom_t              st_geom_q;
  logic               st_azero_q, st_ezero_q;

  // closest-point difference vector
  logic                      pr_vld_q;
  logic signed [VPROD_W-1:0] ps_q [3];
  logic signed [VPROD_W-1:0] pt_q [3];
  logic [2:0][DIFF_W-1:0]    pr_r_q;
  logic                      v_vld_q;
  logic signed [V_W-1:0]     v_q [3];

  // squares and root
  logic [MUL_LAT-1:0]       sq_vld_q;
  logic signed [WIDE_W-1:0] sq [3];
  logic                     rad_vld_q;
  logic [WIDE_W-1:0]        sum;
  logic [SQ_W-1:0]          rad_q;
  logic                     rt_vld;
  logic [SQ_ROOT_W-1:0]     root;
  logic                     done_q;
  logic [DIST_W-1:0]        dist_q;

  assign busy_o = 1'b0;
  assign in_acc = start_i && !busy_o;

  ssd_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .p1_i    ({seg1_start_z_i, seg1_start_y_i, seg1_start_x_i}),
    .q1_i    ({seg1_end_z_i, seg1_end_y_i, seg1_end_x_i}),
    .p2_i    ({seg2_start_z_i, seg2_start_y_i, seg2_start_x_i}),
    .q2_i    ({seg2_end_z_i, seg2_end_y_i, seg2_end_x_i}),
    .valid_o (dot_vld),
    .dots_o  (dots),
    .geom_o  (geom)
  );

  ssd_mul u_mul_ae (.clk_i(clk_i), .x_i(dots.a), .y_i(dots.e), .p_o(p_ae));
  ssd_mul u_mul_bb (.clk_i(clk_i), .x_i(dots.b), .y_i(dots.b), .p_o(p_bb));
  ssd_mul u_mul_bf (.clk_i(clk_i), .x_i(dots.b), .y_i(dots.f), .p_o(p_bf));
  ssd_mul u_mul_ce (.clk_i(clk_i), .x_i(dots.c), .y_i(dots.e), .p_o(p_ce));

  // parallel or degenerate segments leave a non-positive denominator: s0 is zero
  assign num1 = (!den_q[WIDE_W-1] && (den_q != '0)) ? snum_q : '0;

  ssd_div u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_vld_q),
    .num_i   (num1),
    .den_i   (den_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo)
  );

  assign tnum_d = $signed(dv1_q[DIV_LAT-1].dots.b) * $signed({1'b0, d1_quo})
                + (TNUM_W'(dv1_q[DIV_LAT-1].dots.f) <<< PARAM_FRAC);
  assign tden_d = TNUM_W'(dv1_q[DIV_LAT-1].dots.e) <<< PARAM_FRAC;

  always_comb begin
    c_side_d.geom   = t_side_q.geom;
    c_side_d.a_zero = t_side_q.a_zero;
    c_side_d.e_zero = t_side_q.e_zero;
    c_side_d.s_div  = 1'b0;
    c_side_d.s_fix  = '0;
    c_side_d.t_fix  = '0;
    num2_d          = '0;
    den2_d          = DIV_W'(t_side_q.dots.a);
    if (t_side_q.a_zero && t_side_q.e_zero) begin
      num2_d = '0;
    end else if (t_side_q.a_zero) begin
      num2_d = DIV_W'(t_side_q.dots.f);
      den2_d = DIV_W'(t_side_q.dots.e);
    end else if (t_side_q.e_zero || tnum_q[TNUM_W-1]) begin
      // t clamps to zero, s recomputed against segment one alone
      c_side_d.s_div = 1'b1;
      num2_d         = -DIV_W'(t_side_q.dots.c);
    end else if (tnum_q > tden_q) begin
      c_side_d.s_div = 1'b1;
      c_side_d.t_fix = PARAM_ONE;
      num2_d         = DIV_W'(t_side_q.dots.b) - DIV_W'(t_side_q.dots.c);
    end else begin
      c_side_d.s_fix = s0_q;
      num2_d         = DIV_W'(tnum_q);
      den2_d         = DIV_W'(tden_q);
    end
  end

  ssd_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo)
  );

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ssd_mul u_mul_sq (
      .clk_i (clk_i),
      .x_i   (MUL_W'(v_q[i])),
      .y_i   (MUL_W'(v_q[i])),
      .p_o   (sq[i])
    );
  end

  assign sum = WIDE_W'(sq[0]) + WIDE_W'(sq[1]) + WIDE_W'(sq[2]);

  ssd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rad_vld_q),
    .rad_i   (rad_q),
    .valid_o (rt_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= '0;
      n_vld_q   <= 1'b0;
      t_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      st_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
      v_vld_q   <= 1'b0;
      sq_vld_q  <= '0;
      rad_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      m_vld_q   <= {m_vld_q[MUL_LAT-2:0], dot_vld};
      n_vld_q   <= m_vld_q[MUL_LAT-1];
      t_vld_q   <= d1_vld;
      c_vld_q   <= t_vld_q;
      st_vld_q  <= d2_vld;
      pr_vld_q  <= st_vld_q;
      v_vld_q   <= pr_vld_q;
      sq_vld_q  <= {sq_vld_q[MUL_LAT-2:0], v_vld_q};
      rad_vld_q <= sq_vld_q[MUL_LAT-1];
      done_q    <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q[0].dots   <= dots;
    m_side_q[0].geom   <= geom;
    m_side_q[0].a_zero <= dots.a == '0;
    m_side_q[0].e_zero <= dots.e == '0;
    for (int k = 1; k < MUL_LAT; k++) begin
      m_side_q[k] <= m_side_q[k-1];
    end

    den_q    <= p_ae - p_bb;
    snum_q   <= p_bf - p_ce;
    n_side_q <= m_side_q[MUL_LAT-1];

    dv1_q[0] <= n_side_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      dv1_q[k] <= dv1_q[k-1];
    end

    tnum_q   <= tnum_d;
    tden_q   <= tden_d;
    s0_q     <= d1_quo;
    t_side_q <= dv1_q[DIV_LAT-1];

    num2_q   <= num2_d;
    den2_q   <= den2_d;
    c_side_q <= c_side_d;

    dv2_q[0] <= c_side_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      dv2_q[k] <= dv2_q[k-1];
    end

    s_q        <= dv2_q[DIV_LAT-1].s_div ? d2_quo : dv2_q[DIV_LAT-1].s_fix;
    t_q        <= dv2_q[DIV_LAT-1].s_div ? dv2_q[DIV_LAT-1].t_fix : d2_quo;
    st_geom_q  <= dv2_q[DIV_LAT-1].geom;
    st_azero_q <= dv2_q[DIV_LAT-1].a_zero;
    st_ezero_q <= dv2_q[DIV_LAT-1].e_zero;

    for (int i = 0; i < 3; i++) begin
      ps_q[i] <= $signed(st_geom_q.d1[i]) * $signed({1'b0, s_q});
      pt_q[i] <= $signed(st_geom_q.d2[i]) * $signed({1'b0, t_q});
      v_q[i]  <= (V_W'($signed(pr_r_q[i])) <<< PARAM_FRAC)
               + V_W'(ps_q[i]) - V_W'(pt_q[i]);
    end
    pr_r_q <= st_geom_q.r;

    // the root of the squared length, rescaled to Q58.0 by dropping its 32 fraction bits, is the root of its top bits
    rad_q  <= sum[SQ_W+RAD_LSB-1:RAD_LSB];
    dist_q <= root[DIST_W-1:0];
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;

  `SSD_ASSERT_IMP(a_done_lat, done_o, $past(start_i && !busy_o, LATENCY))
  `SSD_ASSERT_IMP(a_param_range, st_vld_q, (s_q <= PARAM_ONE) && (t_q <= PARAM_ONE))
  `SSD_ASSERT_IMP(a_seg1_point, st_vld_q && st_azero_q, s_q == '0)
  `SSD_ASSERT_IMP(a_seg2_point, st_vld_q && st_ezero_q, t_q == '0)

endmodule
